[src/txtint_pkg.sv]
// ----------------------------------------------------------------------------
// txtint_pkg
// Shared types and constants for the text to int64 parser.
// ----------------------------------------------------------------------------
package txtint_pkg;

  // Parse phase, one-hot
  typedef enum logic [3:0] {
    PhSkip   = 4'b0001,
    PhSign   = 4'b0010,
    PhDigits = 4'b0100,
    PhDrain  = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoDigits = 2'd1,
    StPosOvf   = 2'd2,
    StNegOvf   = 2'd3
  } status_e;

  localparam int unsigned RadixWidth = 6;
  localparam int unsigned CharWidth  = 8;

  localparam logic [RadixWidth-1:0] RadixReset = 6'd10;
  localparam logic [RadixWidth-1:0] RadixMin   = 6'd2;
  localparam logic [RadixWidth-1:0] RadixMax   = 6'd36;  // ten digits plus 26 letters

  localparam logic [CharWidth-1:0] CharNul   = 8'h00;
  localparam logic [CharWidth-1:0] CharTab   = 8'h09;
  localparam logic [CharWidth-1:0] CharCr    = 8'h0D;
  localparam logic [CharWidth-1:0] CharSpace = 8'h20;
  localparam logic [CharWidth-1:0] CharPlus  = 8'h2B;
  localparam logic [CharWidth-1:0] CharMinus = 8'h2D;
  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharNine  = 8'h39;
  localparam logic [CharWidth-1:0] CharUpA   = 8'h41;
  localparam logic [CharWidth-1:0] CharUpZ   = 8'h5A;
  localparam logic [CharWidth-1:0] CharLowA  = 8'h61;
  localparam logic [CharWidth-1:0] CharLowZ  = 8'h7A;

  localparam logic signed [63:0] Int64Max = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Int64Min = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic                  alnum;
    logic [RadixWidth-1:0] value;
  } digit_t;

  // Digit value of an alphanumeric character
  function automatic digit_t digit_of(logic [CharWidth-1:0] c);
    digit_t d;
    logic [CharWidth-1:0] diff;
    d.alnum = 1'b0;
    d.value = '0;
    diff    = '0;
    if (c >= CharZero && c <= CharNine) begin
      d.alnum = 1'b1;
      diff    = c - CharZero;
    end else if (c >= CharUpA && c <= CharUpZ) begin
      d.alnum = 1'b1;
      diff    = c - CharUpA + 8'd10;
    end else if (c >= CharLowA && c <= CharLowZ) begin
      d.alnum = 1'b1;
      diff    = c - CharLowA + 8'd10;
    end
    d.value = diff[RadixWidth-1:0];
    return d;
  endfunction

endpackage

[src/txtint_char_if.sv]
// ----------------------------------------------------------------------------
// txtint_char_if
// Character channel: one character code per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface txtint_char_if;
  logic                                valid;
  logic                                ready;
  logic [txtint_pkg::CharWidth-1:0]    char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

[src/txtint_res_if.sv]
// ----------------------------------------------------------------------------
// txtint_res_if
// Result channel: parsed value, status and stop position per word.
// ----------------------------------------------------------------------------
interface txtint_res_if #(
  parameter int unsigned PosWidth = 16
);
  logic                     valid;
  logic                     ready;
  logic signed [63:0]       value;
  txtint_pkg::status_e      status;
  logic [PosWidth-1:0]      stop_position;

  modport source (output valid, output value, output status, output stop_position,
                  input ready);
  modport sink   (input valid, input value, input status, input stop_position,
                  output ready);
endinterface

[src/text_to_int64_parser_unit.sv]
// ----------------------------------------------------------------------------
// text_to_int64_parser_unit
// Streaming signed integer parser for NUL-terminated strings in base 2..36.
// ----------------------------------------------------------------------------
// Usage:
//  - char_i carries one character code per word; a NUL ends the string.
//  - Leading whitespace is skipped, one '+' or '-' is taken, then digits of
//    the current radix are accumulated. The first character that is not
//    consumed produces one word on res_o: value, status, stop position.
//    Further characters up to the NUL are swallowed, then the parser rearms.
//  - Radix: the user writes radix_we_i / radix_i only whilst idle, which the
//    block does not enforce; below 2 acts as 2, above 36 as 36. Resets to 10.
//  - Throughput: one character per cycle while char_i.ready is high. The
//    per-character multiply-add (64 x 6 bit) and overflow compare feed the
//    next parse state; the result register is loaded from the parse state.
//  - Latency: the result word appears on res_o the cycle after the
//    terminating character is accepted.
//  - Stall: char_i.ready is high while the result register is empty or being
//    emptied, so characters keep flowing until an unread result blocks them.
//  - Reset clears parse state and the result valid; radix returns to 10.
// ----------------------------------------------------------------------------
module text_to_int64_parser_unit #(
  parameter int unsigned POS_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                radix_we_i,
  input  logic [txtint_pkg::RadixWidth-1:0]   radix_i,
  txtint_char_if.sink                         char_i,
  txtint_res_if.source                        res_o
);

  localparam int unsigned ProdWidth = 64 + txtint_pkg::RadixWidth;

  // Radix register
  logic [txtint_pkg::RadixWidth-1:0] radix_q;
  logic [txtint_pkg::RadixWidth-1:0] radix_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= txtint_pkg::RadixReset;
    end else if (radix_we_i) begin
      radix_q <= radix_i;
    end
  end

  always_comb begin
    priority if (radix_q < txtint_pkg::RadixMin) begin
      radix_eff = txtint_pkg::RadixMin;
    end else if (radix_q > txtint_pkg::RadixMax) begin
      radix_eff = txtint_pkg::RadixMax;
    end else begin
      radix_eff = radix_q;
    end
  end

  // Parse state
  txtint_pkg::phase_e    phase_q, phase_d;
  logic                  neg_q, neg_d;
  logic [63:0]           acc_q, acc_d;       // magnitude, at most 2^63
  logic                  ovf_q, ovf_d;
  logic                  saw_q, saw_d;
  logic [POS_WIDTH-1:0]  pos_q, pos_d;

  // Result register
  logic                  out_valid_q, out_valid_d;
  logic signed [63:0]    out_value_q, out_value_d;
  txtint_pkg::status_e   out_status_q, out_status_d;
  logic [POS_WIDTH-1:0]  out_pos_q, out_pos_d;

  logic                  accept;
  logic                  emit;
  logic [7:0]            c;
  txtint_pkg::digit_t    dig;
  logic                  is_digit;
  logic                  is_space;
  logic                  is_sign;
  logic [POS_WIDTH-1:0]  pos_inc;
  logic [ProdWidth-1:0]  acc_next;
  logic [ProdWidth-1:0]  limit;
  logic                  add_ovf;

  assign char_i.ready = !out_valid_q || res_o.ready;
  assign accept       = char_i.valid && char_i.ready;

  assign c        = char_i.char_code;
  assign dig      = txtint_pkg::digit_of(c);
  assign is_digit = dig.alnum && (dig.value < radix_eff);
  assign is_space = (c == txtint_pkg::CharSpace) ||
                    (c >= txtint_pkg::CharTab && c <= txtint_pkg::CharCr);
  assign is_sign  = (c == txtint_pkg::CharPlus) || (c == txtint_pkg::CharMinus);

  // Position saturates at all ones
  assign pos_inc = (pos_q == {POS_WIDTH{1'b1}}) ? pos_q : pos_q + 1'b1;

  // Exact next magnitude; overflow when it passes the signed limit
  assign acc_next = ProdWidth'(acc_q) * ProdWidth'(radix_eff) + ProdWidth'(dig.value);
  assign limit    = neg_q ? ProdWidth'(64'h8000_0000_0000_0000)
                          : ProdWidth'(64'h7FFF_FFFF_FFFF_FFFF);
  assign add_ovf  = acc_next > limit;

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    saw_d   = saw_q;
    pos_d   = pos_q;
    emit    = 1'b0;
    unique case (phase_q)
      txtint_pkg::PhDrain: begin
        if (c == txtint_pkg::CharNul) begin
          phase_d = txtint_pkg::PhSkip;
          neg_d   = 1'b0;
          acc_d   = '0;
          ovf_d   = 1'b0;
          saw_d   = 1'b0;
          pos_d   = '0;
        end
      end
      txtint_pkg::PhSkip, txtint_pkg::PhSign, txtint_pkg::PhDigits: begin
        priority if (phase_q == txtint_pkg::PhSkip && is_space) begin
          pos_d = pos_inc;
        end else if (phase_q == txtint_pkg::PhSkip && is_sign) begin
          neg_d   = (c == txtint_pkg::CharMinus);
          phase_d = txtint_pkg::PhSign;
          pos_d   = pos_inc;
        end else if (is_digit) begin
          saw_d   = 1'b1;
          phase_d = txtint_pkg::PhDigits;
          pos_d   = pos_inc;
          if (!ovf_q) begin
            if (add_ovf) begin
              ovf_d = 1'b1;
            end else begin
              acc_d = acc_next[63:0];
            end
          end
        end else begin
          emit = 1'b1;
          if (c == txtint_pkg::CharNul) begin
            phase_d = txtint_pkg::PhSkip;
            neg_d   = 1'b0;
            acc_d   = '0;
            ovf_d   = 1'b0;
            saw_d   = 1'b0;
            pos_d   = '0;
          end else begin
            phase_d = txtint_pkg::PhDrain;
          end
        end
      end
      default: begin
        phase_d = txtint_pkg::PhSkip;
        neg_d   = 1'b0;
        acc_d   = '0;
        ovf_d   = 1'b0;
        saw_d   = 1'b0;
        pos_d   = '0;
      end
    endcase
  end

  // Result word formed from the state before the stopping character
  always_comb begin
    priority if (ovf_q) begin
      out_value_d  = neg_q ? txtint_pkg::Int64Min : txtint_pkg::Int64Max;
      out_status_d = neg_q ? txtint_pkg::StNegOvf : txtint_pkg::StPosOvf;
    end else if (!saw_q) begin
      out_value_d  = '0;
      out_status_d = txtint_pkg::StNoDigits;
    end else begin
      out_value_d  = neg_q ? -$signed(acc_q) : $signed(acc_q);
      out_status_d = txtint_pkg::StOk;
    end
    out_pos_d = pos_q;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && emit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= txtint_pkg::PhSkip;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      saw_q       <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
        ovf_q   <= ovf_d;
        saw_q   <= saw_d;
        pos_q   <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_pos_q    <= out_pos_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.value         = out_value_q;
  assign res_o.status        = out_status_q;
  assign res_o.stop_position = out_pos_q;

endmodule

[src/txtint_checker.sv]
// ----------------------------------------------------------------------------
// txtint_checker
// Port-level assertions for the text to int64 parser, bound to the top level.
// ----------------------------------------------------------------------------
module txtint_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 res_valid_i,
  input  logic                 res_ready_i,
  input  logic signed [63:0]   res_value_i,
  input  txtint_pkg::status_e  res_status_i
);

  // A held result stays until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result word dropped before it was taken");

  // An unread result blocks the character side
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |-> !in_ready_i)
    else $error("character taken while result register full");

  // A fresh result follows an accepted character
  a_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !$past(res_valid_i && !res_ready_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result word without a character");

  // No digits gives zero
  a_nodig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i == txtint_pkg::StNoDigits |-> res_value_i == '0)
    else $error("no-digit result with non-zero value");

  // Overflow saturates
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_status_i == txtint_pkg::StPosOvf ||
                    res_status_i == txtint_pkg::StNegOvf) |->
      (res_status_i == txtint_pkg::StPosOvf && res_value_i == txtint_pkg::Int64Max) ||
      (res_status_i == txtint_pkg::StNegOvf && res_value_i == txtint_pkg::Int64Min))
    else $error("overflow result not saturated");

endmodule

bind text_to_int64_parser_unit txtint_checker u_txtint_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (char_i.valid),
  .in_ready_i   (char_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_value_i  (res_o.value),
  .res_status_i (res_o.status)
);

[verif/tb_text_to_int64_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_to_int64_parser_unit
// Self-checking bench for the streaming text to int64 parser. A short table
// of directed strings is followed by random strings over a dozen radix
// settings and three idle mixes. Every result word is checked against a
// cycle-free parser model kept in this file, or a word typed in by hand.
// ----------------------------------------------------------------------------
module tb_text_to_int64_parser_unit;

  localparam int unsigned PosW      = 16;
  localparam int          NotDigit  = 99;
  localparam int          StallMax  = 3000;  // cycles without any word moving
  localparam int          HoldOff   = 400;   // long receiver stall
  localparam int          SubChars  = 130;   // characters per radix setting

  // One result word as seen on res_o
  typedef struct packed {
    logic signed [63:0]  value;
    txtint_pkg::status_e status;
    logic [PosW-1:0]     stop_pos;
  } parse_res_t;

  // Directed row: optional radix write first, then the characters
  typedef struct {
    int         radix_wr;  // -1 leaves the radix alone
    string      text;
    bit         with_nul;
    bit         typed;     // result typed in below rather than predicted
    parse_res_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic radix_we;
  logic [txtint_pkg::RadixWidth-1:0] radix_wdata;

  txtint_char_if                  char_bus ();
  txtint_res_if #(.PosWidth(PosW)) res_bus ();

  text_to_int64_parser_unit #(
    .POS_WIDTH (PosW)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .radix_we_i (radix_we),
    .radix_i    (radix_wdata),
    .char_i     (char_bus),
    .res_o      (res_bus)
  );

  // --------------------------------------------------------------------------
  // Parser model state; radix_cfg mirrors the radix register
  // --------------------------------------------------------------------------
  logic [txtint_pkg::RadixWidth-1:0] radix_cfg = txtint_pkg::RadixReset;
  txtint_pkg::phase_e                parse_ph  = txtint_pkg::PhSkip;
  logic                              neg_sign  = 1'b0;
  logic [63:0]                       magnitude = '0;
  logic                              ovf_seen  = 1'b0;
  logic                              got_digit = 1'b0;
  logic [PosW-1:0]                   char_pos  = '0;

  parse_res_t pending_results [$];  // predicted words not yet received
  parse_res_t typed_results [$];    // hand-written words for directed rows

  int snd_idle_pct = 12;
  int rcv_idle_pct = 86;
  bit hold_req     = 1'b0;
  int hold_left    = 0;

  int n_chars   = 0;
  int n_strings = 0;
  int n_results = 0;
  int n_cfg     = 0;
  int n_err     = 0;
  int quiet_cyc = 0;

  dir_row_t dir_rows [6] = '{
    // bare terminator straight out of reset, radix 10
    '{-1, "", 1'b1, 1'b1, '{64'sd0, txtint_pkg::StNoDigits, 16'd0}},
    // sign with no digits: stop points past the sign
    '{-1, "-", 1'b1, 1'b1, '{64'sd0, txtint_pkg::StNoDigits, 16'd1}},
    // tab, CR and space skipped, '+', one digit, stopped by 0xFF, NUL drained
    '{-1, " \t\015+7\377", 1'b1, 1'b1, '{64'sd7, txtint_pkg::StOk, 16'd5}},
    // base 2: '2' is not a digit
    '{2, "12", 1'b1, 1'b1, '{64'sd1, txtint_pkg::StOk, 16'd1}},
    // radix 0 acts as 2; string left open for the next row
    '{0, "1", 1'b0, 1'b0, '{64'sd0, txtint_pkg::StOk, 16'd0}},
    // radix 63 written mid-string acts as 36 for the letter
    '{63, "Z", 1'b1, 1'b0, '{64'sd0, txtint_pkg::StOk, 16'd0}}
  };

  // --------------------------------------------------------------------------
  // Model helpers
  // --------------------------------------------------------------------------
  function automatic int eff_radix(logic [txtint_pkg::RadixWidth-1:0] r);
    if (r < txtint_pkg::RadixMin) return int'(txtint_pkg::RadixMin);
    if (r > txtint_pkg::RadixMax) return int'(txtint_pkg::RadixMax);
    return int'(r);
  endfunction

  function automatic int digit_val(logic [txtint_pkg::CharWidth-1:0] c);
    if (c >= txtint_pkg::CharZero && c <= txtint_pkg::CharNine)
      return int'(c - txtint_pkg::CharZero);
    if (c >= txtint_pkg::CharUpA && c <= txtint_pkg::CharUpZ)
      return int'(c - txtint_pkg::CharUpA) + 10;
    if (c >= txtint_pkg::CharLowA && c <= txtint_pkg::CharLowZ)
      return int'(c - txtint_pkg::CharLowA) + 10;
    return NotDigit;
  endfunction

  function automatic void rearm_parser();
    parse_ph  = txtint_pkg::PhSkip;
    neg_sign  = 1'b0;
    magnitude = '0;
    ovf_seen  = 1'b0;
    got_digit = 1'b0;
    char_pos  = '0;
  endfunction

  function automatic void bump_pos();
    if (char_pos != '1) char_pos++;
  endfunction

  // Advances the model by one accepted character; returns 1 when a word is due
  function automatic bit parse_char(input logic [txtint_pkg::CharWidth-1:0] c,
                                    output parse_res_t res);
    int          d;
    logic [63:0] rw;
    logic [63:0] lim;
    d   = digit_val(c);
    rw  = 64'(eff_radix(radix_cfg));
    res = '0;
    if (parse_ph == txtint_pkg::PhDrain) begin
      if (c == txtint_pkg::CharNul) rearm_parser();
      return 1'b0;
    end
    if (parse_ph == txtint_pkg::PhSkip) begin
      if (c == txtint_pkg::CharSpace ||
          (c >= txtint_pkg::CharTab && c <= txtint_pkg::CharCr)) begin
        bump_pos();
        return 1'b0;
      end
      if (c == txtint_pkg::CharPlus || c == txtint_pkg::CharMinus) begin
        neg_sign = (c == txtint_pkg::CharMinus);
        parse_ph = txtint_pkg::PhSign;
        bump_pos();
        return 1'b0;
      end
    end
    if (c != txtint_pkg::CharNul && 64'(d) < rw) begin
      // negative side may reach 2^63, positive side only 2^63 - 1
      lim       = neg_sign ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      got_digit = 1'b1;
      if (!ovf_seen) begin
        if (magnitude > (lim - 64'(d)) / rw) ovf_seen = 1'b1;
        else magnitude = magnitude * rw + 64'(d);
      end
      parse_ph = txtint_pkg::PhDigits;
      bump_pos();
      return 1'b0;
    end
    res.stop_pos = char_pos;
    if (ovf_seen) begin
      res.value  = neg_sign ? txtint_pkg::Int64Min : txtint_pkg::Int64Max;
      res.status = neg_sign ? txtint_pkg::StNegOvf : txtint_pkg::StPosOvf;
    end else if (!got_digit) begin
      res.value  = '0;
      res.status = txtint_pkg::StNoDigits;
    end else begin
      res.value  = neg_sign ? -magnitude : magnitude;
      res.status = txtint_pkg::StOk;
    end
    if (c == txtint_pkg::CharNul) rearm_parser();
    else parse_ph = txtint_pkg::PhDrain;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    rst_n                = 1'b0;
    radix_we             = 1'b0;
    radix_wdata          = '0;
    char_bus.valid       = 1'b0;
    char_bus.char_code   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready at the falling edge, with a single long
  // hold-off counted here so the sender keeps pushing into a full block
  // --------------------------------------------------------------------------
  initial begin
    res_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldOff;
      end
      if (hold_left > 0) begin
        res_bus.ready = 1'b0;
        hold_left--;
      end else begin
        res_bus.ready = ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: feeds accepted characters to the model, checks result words
  // against the oldest prediction, and runs the watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    parse_res_t got;
    parse_res_t want;
    bit         moved;
    moved = 1'b0;
    if (rst_n) begin
      if (char_bus.valid && char_bus.ready) begin
        moved = 1'b1;
        n_chars++;
        if (parse_char(char_bus.char_code, want)) begin
          // directed rows with a typed result override the model's word
          if (typed_results.size() != 0) want = typed_results.pop_front();
          pending_results.push_back(want);
        end
      end
      if (res_bus.valid && res_bus.ready) begin
        moved        = 1'b1;
        n_results++;
        got.value    = res_bus.value;
        got.status   = res_bus.status;
        got.stop_pos = res_bus.stop_position;
        if (pending_results.size() == 0) begin
          n_err++;
          $display("%0t: unexpected word: value %0d status %0d stop %0d", $time,
                   got.value, got.status, got.stop_pos);
        end else begin
          want = pending_results.pop_front();
          if (got.value !== want.value) begin
            n_err++;
            $display("%0t: value mismatch: expected %0d, actual %0d", $time,
                     want.value, got.value);
          end
          if (got.status !== want.status) begin
            n_err++;
            $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                     want.status, got.status);
          end
          if (got.stop_pos !== want.stop_pos) begin
            n_err++;
            $display("%0t: stop position mismatch: expected %0d, actual %0d", $time,
                     want.stop_pos, got.stop_pos);
          end
        end
      end
      if (moved) begin
        quiet_cyc = 0;
      end else begin
        quiet_cyc++;
        if (quiet_cyc >= StallMax) begin
          $display("%0t: watchdog: nothing moved for %0d cycles", $time, quiet_cyc);
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  // Offer one character; random gaps only before valid goes high
  task automatic push_char(input logic [txtint_pkg::CharWidth-1:0] c);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      char_bus.valid = 1'b0;
      @(negedge clk);
    end
    char_bus.valid     = 1'b1;
    char_bus.char_code = c;
    do @(posedge clk); while (!char_bus.ready);
  endtask

  task automatic sender_rest();
    @(negedge clk);
    char_bus.valid = 1'b0;
  endtask

  task automatic send_string(input logic [txtint_pkg::CharWidth-1:0] s [$]);
    foreach (s[i]) push_char(s[i]);
    n_strings++;
  endtask

  // Radix write only with nothing in flight: drain words, allow the
  // pipeline to settle, then a single write strobe
  task automatic set_radix(input logic [txtint_pkg::RadixWidth-1:0] v);
    sender_rest();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    radix_we    = 1'b1;
    radix_wdata = v;
    @(negedge clk);
    radix_we    = 1'b0;
    radix_cfg   = v;
    n_cfg++;
  endtask

  function automatic logic [txtint_pkg::CharWidth-1:0] digit_char(int d);
    if (d < 10) return txtint_pkg::CharZero + txtint_pkg::CharWidth'(d);
    if ($urandom_range(0, 1) != 0)
      return txtint_pkg::CharUpA + txtint_pkg::CharWidth'(d - 10);
    return txtint_pkg::CharLowA + txtint_pkg::CharWidth'(d - 10);
  endfunction

  // Mostly well-formed numbers in the current base, some noise
  task automatic build_string(output logic [txtint_pkg::CharWidth-1:0] s [$]);
    int                               r;
    int                               n;
    int                               sel;
    int                               lead;
    logic [63:0]                      m;
    logic [63:0]                      rw;
    logic [txtint_pkg::CharWidth-1:0] c;
    logic [txtint_pkg::CharWidth-1:0] digs [$];
    s    = {};
    lead = 0;
    r    = eff_radix(radix_cfg);
    rw   = 64'(r);
    if ($urandom_range(0, 99) < 80) begin
      if ($urandom_range(0, 99) < 30) begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          c = txtint_pkg::CharWidth'($urandom_range(8, 13));
          s.push_back(c == 8'd8 ? txtint_pkg::CharSpace : c);
        end
      end
      case ($urandom_range(0, 2))
        1: s.push_back(txtint_pkg::CharPlus);
        2: s.push_back(txtint_pkg::CharMinus);
        default: ;
      endcase
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1, 2, 3: m = 64'($urandom_range(0, 1000));
        4, 5:       m = {$urandom, $urandom};
        6:          m = 64'h7FFF_FFFF_FFFF_FFFE + 64'($urandom_range(0, 3));
        7:          m = '1;
        default:    m = 64'($urandom);
      endcase
      if (sel != 9) begin
        // leading zero
        if ($urandom_range(0, 9) == 0) begin
          digs.push_back(txtint_pkg::CharZero);
          lead = 1;
        end
        if (m == 0) digs.push_back(txtint_pkg::CharZero);
        // least significant digit first, each one goes in front of the last
        while (m != 0) begin
          digs.insert(lead, digit_char(int'(m % rw)));
          m = m / rw;
        end
        // occasionally push past 64 bits
        if ($urandom_range(0, 9) == 0) digs.push_back(digit_char($urandom_range(0, r - 1)));
        s = {s, digs};
      end
      if ($urandom_range(0, 99) >= 65) begin
        do c = txtint_pkg::CharWidth'($urandom_range(1, 255)); while (digit_val(c) < r);
        s.push_back(c);
        n = $urandom_range(0, 3);
        repeat (n) s.push_back(txtint_pkg::CharWidth'($urandom_range(1, 255)));
      end
    end else begin
      n = $urandom_range(0, 6);
      repeat (n) s.push_back(txtint_pkg::CharWidth'($urandom_range(1, 255)));
    end
    s.push_back(txtint_pkg::CharNul);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [txtint_pkg::CharWidth-1:0]  str [$];
    logic [txtint_pkg::RadixWidth-1:0] radix_plan [12];
    int sub_chars;

    radix_plan = '{6'd10, 6'd16, 6'd2, 6'd36, 6'd8, 6'd0, 6'd37, 6'd63,
                   6'd1, 6'd3, 6'd35, 6'd10};
    radix_plan[11] = txtint_pkg::RadixWidth'($urandom_range(0, 63));

    wait (rst_n === 1'b1);

    // Directed table, sender dense and receiver slow
    foreach (dir_rows[i]) begin
      if (dir_rows[i].radix_wr >= 0)
        set_radix(txtint_pkg::RadixWidth'(dir_rows[i].radix_wr));
      if (dir_rows[i].typed) typed_results.push_back(dir_rows[i].want);
      str = {};
      for (int j = 0; j < dir_rows[i].text.len(); j++) str.push_back(dir_rows[i].text[j]);
      if (dir_rows[i].with_nul) str.push_back(txtint_pkg::CharNul);
      send_string(str);
    end
    // Positive overflow in base 36: thirteen 'z' already exceed 2^63 - 1
    set_radix(6'd36);
    typed_results.push_back('{txtint_pkg::Int64Max, txtint_pkg::StPosOvf, 16'd13});
    str = {};
    repeat (13) str.push_back(txtint_pkg::CharLowZ);
    str.push_back(txtint_pkg::CharNul);
    send_string(str);

    // Random strings: three idle mixes, four radix settings each
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin snd_idle_pct = 12; rcv_idle_pct = 86; end
        1: begin snd_idle_pct = 86; rcv_idle_pct = 12; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      for (int sub = 0; sub < 4; sub++) begin
        set_radix(radix_plan[mode * 4 + sub]);
        // long hold-off while the sender keeps offering characters
        if (mode == 0 && sub == 1) hold_req = 1'b1;
        sub_chars = 0;
        while (sub_chars < SubChars) begin
          build_string(str);
          send_string(str);
          sub_chars += str.size();
        end
      end
    end

    // Back to the reset radix for a last short negative number
    set_radix(txtint_pkg::RadixReset);
    str = {txtint_pkg::CharMinus, txtint_pkg::CharZero + 8'd5, txtint_pkg::CharNul};
    send_string(str);

    sender_rest();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d characters in %0d strings; %0d result words checked, %0d radix writes.",
             n_chars, n_strings, n_results, n_cfg);
    $display("Covered: radix clamping, overflow edges, idle mixes, long hold-off.");
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
src/txtint_pkg.sv
src/txtint_char_if.sv
src/txtint_res_if.sv
src/text_to_int64_parser_unit.sv
src/txtint_checker.sv
verif/tb_text_to_int64_parser_unit.sv
